[rtl/core/stream_buffer_refill_control_macros.svh]
// assertion macros for the checker file of the refill controller
`ifndef STREAM_BUFFER_REFILL_CONTROL_MACROS_SVH
`define STREAM_BUFFER_REFILL_CONTROL_MACROS_SVH

// same-cycle implication, checked outside reset
`define SBRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SBRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/sbrc_pkg.sv]
// shared constants, command and status types of the refill controller
`default_nettype none

package sbrc_pkg;

    localparam int MAX_REQUESTS = 16;
    localparam int REQ_CNT_W    = $clog2(MAX_REQUESTS + 1);

    localparam int TIME_W     = 32;
    localparam int SMP_W      = 16;
    localparam int THR_W      = SMP_W - 1;
    localparam int FILL_W     = TIME_W + 1;
    localparam int PROD_W     = TIME_W + SMP_W;
    localparam int DVS_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SAMPLES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 2'd2;

    localparam logic [SMP_W-1:0]  RATE_RESET = 16'd32768;
    localparam logic [SMP_W-1:0]  BUF_RESET  = 16'd4096;
    localparam logic [DVS_W-1:0]  TPS_RESET  = 32'd33513982;

    localparam logic KIND_START = 1'b0;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_RESYNC,
        OP_MUL,
        OP_CLEAR_Q,
        OP_DIV_Q,
        OP_DIV_ADV,
        OP_TAKE_ADV,
        OP_UPDATE,
        OP_PREP,
        OP_ADD,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic   capture;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_start;
        logic late;
        logic conv_ok;
        logic div_done;
        logic refill_needed;
        logic last_req;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/core/sbrc_div.sv]
// serial restoring divider, one quotient bit per cycle
`default_nettype none

module sbrc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sbrc_pkg::PROD_W-1:0] dividend,
    input  logic [sbrc_pkg::DVS_W-1:0]  divisor,
    output logic                        done,
    output logic [sbrc_pkg::PROD_W-1:0] quotient,
    output logic [sbrc_pkg::DVS_W-1:0]  remainder
);
    import sbrc_pkg::*;

    localparam int STEP_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] quo_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DVS_W:0] rem_shift;
    logic           fits;
    logic [DVS_W:0] rem_sub;

    assign rem_shift = {rem_reg, quo_reg[PROD_W-1]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(PROD_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[PROD_W-2:0], fits};
            rem_reg <= fits ? rem_sub[DVS_W-1:0] : rem_shift[DVS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[rtl/core/sbrc_dp.sv]
// datapath: config registers, stream state, conversion and refill word
`default_nettype none

module sbrc_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [sbrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sbrc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            kind,
    input  logic [sbrc_pkg::TIME_W-1:0]     bus_time,
    input  sbrc_pkg::dp_cmd_t               cmd,
    output sbrc_pkg::dp_status_t            status,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic [sbrc_pkg::SMP_W-1:0]      fill_offset,
    output logic [sbrc_pkg::SMP_W-1:0]      fill_count,
    output logic                            last,
    output logic                            overrun,
    output logic [sbrc_pkg::TIME_W-1:0]     played_total
);
    import sbrc_pkg::*;

    localparam logic [FILL_W-1:0] FILL_MIN  = {1'b1, {TIME_W{1'b0}}};
    localparam logic [FILL_W:0]   FILL_BIAS = {2'b01, {TIME_W{1'b0}}};

    // config
    logic [SMP_W-1:0]  rate_reg;
    logic [SMP_W-1:0]  buf_reg;
    logic [DVS_W-1:0]  tps_reg;

    // stream state
    logic [TIME_W-1:0]    ref_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic [SMP_W-1:0]     wo_reg;
    logic [TIME_W-1:0]    played_reg;
    logic [REQ_CNT_W-1:0] n_reg;
    logic                 out_valid_reg;

    // work registers
    logic              kind_reg;
    logic [TIME_W-1:0] time_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] q_reg;
    logic [TIME_W-1:0] adv_reg;
    logic [SMP_W-1:0]  cnt_reg;
    logic [SMP_W-1:0]  pend_off_reg;
    logic [SMP_W-1:0]  pend_cnt_reg;
    logic [SMP_W-1:0]  off_out_reg;
    logic [SMP_W-1:0]  cnt_out_reg;
    logic              last_out_reg;
    logic              ovr_out_reg;
    logic [TIME_W-1:0] played_out_reg;

    // divider
    logic              div_start;
    logic [PROD_W-1:0] div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic              div_done;
    logic [PROD_W-1:0] div_quo;
    logic [DVS_W-1:0]  div_rem;

    logic [TIME_W-1:0] elapsed;
    logic [PROD_W-1:0] prod_next;
    logic [SMP_W-1:0]  thr_min;
    logic [THR_W-1:0]  thr;
    logic              fill_le_thr;
    logic [FILL_W:0]   head;
    logic              sat;
    logic [FILL_W-1:0] fill_dec;
    logic [SMP_W-1:0]  wo_wrap;
    logic [SMP_W:0]    end_sum;
    logic [SMP_W-1:0]  cnt_prep;
    logic [SMP_W:0]    wo_sum;
    logic [SMP_W-1:0]  wo_add;
    logic              cap_hit;
    logic              out_free;

    assign elapsed   = time_reg - ref_reg;
    assign prod_next = PROD_W'(elapsed) * PROD_W'(rate_reg);

    assign thr_min     = (rate_reg < buf_reg) ? rate_reg : buf_reg;
    assign thr         = thr_min[SMP_W-1:1];
    assign fill_le_thr = $signed(fill_reg) <= $signed({{(FILL_W-THR_W){1'b0}}, thr});

    // headroom above the saturation floor
    assign head     = {fill_reg[FILL_W-1], fill_reg} + FILL_BIAS;
    assign sat      = q_reg > {{(PROD_W-FILL_W-1){1'b0}}, head};
    assign fill_dec = fill_reg - q_reg[FILL_W-1:0];

    // request formation
    assign wo_wrap  = (wo_reg >= buf_reg) ? '0 : wo_reg;
    assign end_sum  = {1'b0, wo_wrap} + {2'b00, thr};
    assign cnt_prep = (end_sum > {1'b0, buf_reg}) ? (buf_reg - wo_wrap) : {1'b0, thr};
    assign wo_sum   = {1'b0, wo_reg} + {1'b0, cnt_reg};
    assign wo_add   = (wo_sum >= {1'b0, buf_reg}) ? '0 : wo_sum[SMP_W-1:0];

    assign cap_hit  = n_reg == REQ_CNT_W'(MAX_REQUESTS);
    assign out_free = !out_valid_reg || !out_stall;

    assign div_start    = (cmd.op == OP_DIV_Q) || (cmd.op == OP_DIV_ADV);
    assign div_dividend = (cmd.op == OP_DIV_Q) ? prod_reg : (prod_reg - PROD_W'(div_rem));
    assign div_divisor  = (cmd.op == OP_DIV_Q) ? tps_reg : DVS_W'(rate_reg);

    sbrc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // config and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= RATE_RESET;
            buf_reg       <= BUF_RESET;
            tps_reg       <= TPS_RESET;
            ref_reg       <= '0;
            fill_reg      <= '0;
            wo_reg        <= '0;
            played_reg    <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_SAMPLE_RATE:      rate_reg <= cfg_data[SMP_W-1:0];
                    CFG_BUFFER_SAMPLES:   buf_reg  <= cfg_data[SMP_W-1:0];
                    CFG_TICKS_PER_SECOND: tps_reg  <= cfg_data[DVS_W-1:0];
                    default:              ;
                endcase
            end

            if (cmd.op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (cmd.op)
                OP_START:
                begin
                    fill_reg <= '0;
                    wo_reg   <= '0;
                    ref_reg  <= time_reg;
                end
                OP_RESYNC:
                begin
                    ref_reg <= time_reg;
                end
                OP_UPDATE:
                begin
                    ref_reg    <= ref_reg + adv_reg;
                    fill_reg   <= sat ? FILL_MIN : fill_dec;
                    played_reg <= played_reg + q_reg[TIME_W-1:0];
                    n_reg      <= '0;
                end
                OP_PREP:
                begin
                    wo_reg <= wo_wrap;
                end
                OP_ADD:
                begin
                    fill_reg <= fill_reg + {{(FILL_W-SMP_W){1'b0}}, cnt_reg};
                    wo_reg   <= wo_add;
                    n_reg    <= n_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            time_reg <= bus_time;
        end

        unique case (cmd.op)
            OP_MUL:
            begin
                prod_reg <= prod_next;
            end
            OP_CLEAR_Q:
            begin
                q_reg   <= '0;
                adv_reg <= '0;
            end
            OP_DIV_ADV:
            begin
                q_reg <= div_quo;
            end
            OP_TAKE_ADV:
            begin
                adv_reg <= div_quo[TIME_W-1:0];
            end
            OP_PREP:
            begin
                cnt_reg <= cnt_prep;
            end
            OP_ADD:
            begin
                pend_off_reg <= wo_reg;
                pend_cnt_reg <= cnt_reg;
            end
            OP_EMIT:
            begin
                off_out_reg    <= pend_off_reg;
                cnt_out_reg    <= pend_cnt_reg;
                last_out_reg   <= !fill_le_thr || cap_hit;
                ovr_out_reg    <= fill_le_thr && cap_hit;
                played_out_reg <= played_reg;
            end
            default: ;
        endcase
    end

    assign status.is_start      = kind_reg == KIND_START;
    assign status.late          = time_reg < ref_reg;
    assign status.conv_ok       = (tps_reg != '0) && (rate_reg != '0);
    assign status.div_done      = div_done;
    assign status.refill_needed = (thr != '0) && fill_le_thr;
    assign status.last_req      = !fill_le_thr || cap_hit;
    assign status.out_free      = out_free;

    assign out_valid    = out_valid_reg;
    assign fill_offset  = off_out_reg;
    assign fill_count   = cnt_out_reg;
    assign last         = last_out_reg;
    assign overrun      = ovr_out_reg;
    assign played_total = played_out_reg;

endmodule

`default_nettype wire

[rtl/core/sbrc_ctrl.sv]
// controller state machine sequencing one item through the datapath
`default_nettype none

module sbrc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  sbrc_pkg::dp_status_t status,
    output sbrc_pkg::dp_cmd_t    cmd
);
    import sbrc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV_Q,
        S_DIV_Q_WAIT,
        S_DIV_A_WAIT,
        S_UPDATE,
        S_CHECK,
        S_PREP,
        S_ADD,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;
    logic   in_stall_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.op      = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall_reg)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.is_start)
                begin
                    cmd.op     = OP_START;
                    state_next = S_IDLE;
                end
                else if (status.late)
                begin
                    cmd.op     = OP_RESYNC;
                    state_next = S_IDLE;
                end
                else if (status.conv_ok)
                begin
                    cmd.op     = OP_MUL;
                    state_next = S_DIV_Q;
                end
                else
                begin
                    cmd.op     = OP_CLEAR_Q;
                    state_next = S_UPDATE;
                end
            end
            S_DIV_Q:
            begin
                cmd.op     = OP_DIV_Q;
                state_next = S_DIV_Q_WAIT;
            end
            S_DIV_Q_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_DIV_ADV;
                    state_next = S_DIV_A_WAIT;
                end
            end
            S_DIV_A_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_TAKE_ADV;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.op     = OP_UPDATE;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = status.refill_needed ? S_PREP : S_IDLE;
            end
            S_PREP:
            begin
                cmd.op     = OP_PREP;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.op     = OP_ADD;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = status.last_req ? S_IDLE : S_PREP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        in_stall_next = state_next != S_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= in_stall_next;
        end
    end

    assign in_stall = in_stall_reg;

endmodule

`default_nettype wire

[rtl/core/stream_buffer_refill_control.sv]
// a start word needs no division; a poll with a nonzero rate and tick rate runs
// two 48-step serial divisions in the shared divider before its first refill word,
// then passes prep, add and emit for each word and holds the input until its last
// word is emitted; an out-of-order poll (time before reference) only resyncs
// reset: asynchronous active low, config to defaults, stream state cleared
// one word accepted at a time; output register frees the input side
`default_nettype none

module stream_buffer_refill_control (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_write,
    input  logic [sbrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sbrc_pkg::CFG_DATA_W-1:0] cfg_data,
    // input word channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic [sbrc_pkg::TIME_W-1:0]     bus_time,
    // refill request channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [sbrc_pkg::SMP_W-1:0]      fill_offset,
    output logic [sbrc_pkg::SMP_W-1:0]      fill_count,
    output logic                            last,
    output logic                            overrun,
    output logic [sbrc_pkg::TIME_W-1:0]     played_total
);
    import sbrc_pkg::*;

    // command from the sequencer, status back from the datapath
    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: decodes the word kind, runs the two divisions when the rate and tick
    // rate are nonzero, then loops prep / add / emit once per refill request
    sbrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: elapsed * rate product, serial divider for the sample count
    // and the reference advance, fill level with floor saturation, ring
    // offset wrap and the registered output word
    sbrc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .bus_time     (bus_time),
        .cmd          (cmd),
        .status       (status),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .fill_offset  (fill_offset),
        .fill_count   (fill_count),
        .last         (last),
        .overrun      (overrun),
        .played_total (played_total)
    );

endmodule

`default_nettype wire

[rtl/core/sbrc_checker.sv]
// port-level checker for the refill controller, bound to the top level
`default_nettype none

`include "stream_buffer_refill_control_macros.svh"

module sbrc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [sbrc_pkg::SMP_W-1:0]  fill_offset,
    input logic [sbrc_pkg::SMP_W-1:0]  fill_count,
    input logic                        last,
    input logic                        overrun,
    input logic [sbrc_pkg::TIME_W-1:0] played_total
);

    // stalled word holds
    `SBRC_ASSERT_NEXT(a_out_hold, clk, rst_n, (out_valid && out_stall), (out_valid && $stable(fill_offset) && $stable(fill_count) && $stable(played_total)), "stalled refill word changed")

    // a refill word never asks for zero samples
    `SBRC_ASSERT_NOW(a_count_nonzero, clk, rst_n, out_valid, (fill_count != '0), "empty refill word")

    // overrun only on the closing word of a poll
    `SBRC_ASSERT_NOW(a_overrun_last, clk, rst_n, (out_valid && overrun), last, "overrun without last")

    // a request never runs past the end of the largest possible ring
    `SBRC_ASSERT_NOW(a_in_ring, clk, rst_n, out_valid, (({1'b0, fill_offset} + {1'b0, fill_count}) <= 17'h0FFFF), "refill crosses ring end")

endmodule

bind stream_buffer_refill_control sbrc_checker u_checker (.*);

`default_nettype wire

[test/stream_buffer_refill_control_tb.sv]
// self-checking testbench for the stream buffer refill controller
module stream_buffer_refill_control_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbrc_pkg::*;

    // the input kind that is not a stream start
    localparam logic KIND_POLL = ~KIND_START;
    // index with no register behind it, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // long enough for a poll with a full set of refill words to finish
    localparam int SETTLE_CYCLES     = 300;
    // long receiver hold-off so the output side backs up into the input
    localparam int HOLD_CYCLES       = 800;
    // cycles with no handshake at all before the run is declared hung
    localparam int IDLE_LIMIT        = 5000;
    localparam int RANDOM_SETTINGS   = 5;
    localparam int WORDS_PER_SETTING = 15;

    // one expected refill request
    typedef struct packed {
        logic [SMP_W-1:0]  offset;
        logic [SMP_W-1:0]  count;
        logic              last;
        logic              overrun;
        logic [TIME_W-1:0] played;
    } refill_req_t;

    // predicts refill requests and compares them with what the block sends
    class refill_scoreboard;
        // register copies
        bit [SMP_W-1:0]         rate;
        bit [SMP_W-1:0]         ring_len;
        bit [DVS_W-1:0]         tps;
        // stream state copies
        bit [TIME_W-1:0]        ref_time;
        bit signed [FILL_W-1:0] fill;
        bit [SMP_W-1:0]         wr_offset;
        bit [TIME_W-1:0]        played;
        // refill requests predicted but not yet seen
        refill_req_t            pending[$];
        int                     errors;
        int                     checked;
        int                     overruns;

        function new();
            rate      = RATE_RESET;
            ring_len  = BUF_RESET;
            tps       = TPS_RESET;
            ref_time  = '0;
            fill      = '0;
            wr_offset = '0;
            played    = '0;
            errors    = 0;
            checked   = 0;
            overruns  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SAMPLE_RATE:      rate     = data[SMP_W-1:0];
                CFG_BUFFER_SAMPLES:   ring_len = data[SMP_W-1:0];
                CFG_TICKS_PER_SECOND: tps      = data;
                default: ;
            endcase
        endfunction

        // advance the stream state by one accepted word, queue its refill requests
        function void note_word(logic k, logic [TIME_W-1:0] now);
            bit [TIME_W-1:0]  diff;
            longint unsigned  elapsed;
            longint unsigned  consumed;
            longint unsigned  adv;
            longint           level;
            longint           room;
            int               thr;
            int               stop;
            int               cnt;
            int               n;
            bit               more;
            refill_req_t      req;
            n        = 0;
            consumed = 0;
            if (k == KIND_START) begin
                fill      = '0;
                wr_offset = '0;
                ref_time  = now;
                return;
            end
            // time running backwards only resyncs
            if (now < ref_time) begin
                ref_time = now;
                return;
            end
            // a zero rate or zero tick rate consumes nothing
            if (tps != 0 && rate != 0) begin
                diff     = now - ref_time;
                elapsed  = diff;
                consumed = elapsed * rate / tps;
                adv      = consumed * tps / rate;
                ref_time = ref_time + adv[TIME_W-1:0];
            end
            // fill level bottoms out at minus two to the 32
            level = fill;
            room  = level + (longint'(1) <<< 32);
            if (consumed > unsigned'(room))
                level = -(longint'(1) <<< 32);
            else
                level = level - longint'(consumed);
            played = played + consumed[TIME_W-1:0];
            thr = ((rate < ring_len) ? rate : ring_len) >> 1;
            if (thr != 0) begin
                while (level <= longint'(thr) && n < MAX_REQUESTS) begin
                    if (wr_offset >= ring_len)
                        wr_offset = '0;
                    stop = int'(wr_offset) + thr;
                    if (stop > int'(ring_len))
                        stop = int'(ring_len);
                    cnt         = stop - int'(wr_offset);
                    req.offset  = wr_offset;
                    req.count   = cnt[SMP_W-1:0];
                    req.played  = played;
                    level       = level + cnt;
                    wr_offset   = wr_offset + cnt[SMP_W-1:0];
                    if (wr_offset >= ring_len)
                        wr_offset = '0;
                    more        = (level <= longint'(thr));
                    req.last    = !more || (n + 1 >= MAX_REQUESTS);
                    req.overrun = more && (n + 1 >= MAX_REQUESTS);
                    pending.push_back(req);
                    n++;
                end
            end
            fill = level[FILL_W-1:0];
        endfunction

        function void check_word(logic [SMP_W-1:0] offset, logic [SMP_W-1:0] count,
                                 logic lst, logic ovr, logic [TIME_W-1:0] total);
            refill_req_t want;
            if (pending.size() == 0) begin
                $error("refill word with nothing expected: fill_offset %0d fill_count %0d",
                       offset, count);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (ovr === 1'b1)
                overruns++;
            if (offset !== want.offset) begin
                $error("fill_offset expected %0d actual %0d", want.offset, offset);
                errors++;
            end
            if (count !== want.count) begin
                $error("fill_count expected %0d actual %0d", want.count, count);
                errors++;
            end
            if (lst !== want.last) begin
                $error("last expected %0d actual %0d", want.last, lst);
                errors++;
            end
            if (ovr !== want.overrun) begin
                $error("overrun expected %0d actual %0d", want.overrun, ovr);
                errors++;
            end
            if (total !== want.played) begin
                $error("played_total expected %0d actual %0d", want.played, total);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic                  in_valid;
    logic                  in_stall;
    logic                  kind;
    logic [TIME_W-1:0]     bus_time;

    logic                  out_valid;
    logic                  out_stall;
    logic [SMP_W-1:0]      fill_offset;
    logic [SMP_W-1:0]      fill_count;
    logic                  last;
    logic                  overrun;
    logic [TIME_W-1:0]     played_total;

    refill_scoreboard sb = new();

    // shared between stimulus and receiver
    bit no_gaps      = 1'b0;
    bit hold_pending = 1'b0;

    int starts      = 0;
    int polls       = 0;
    int settings    = 0;
    int idle_cycles = 0;

    stream_buffer_refill_control u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .bus_time     (bus_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .fill_offset  (fill_offset),
        .fill_count   (fill_count),
        .last         (last),
        .overrun      (overrun),
        .played_total (played_total)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offer one input word, after a random gap unless no_gaps is set, and hold it until taken
    task automatic send_word(logic k, logic [TIME_W-1:0] t);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        bus_time <= t;
        // values read here are the ones the block saw at this edge
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_word(k, t);
        if (k == KIND_START)
            starts++;
        else
            polls++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    // wait until every refill word has arrived, then let a trailing
    // poll with no refill words finish inside the block
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // registers change only while the block is idle
    task automatic apply_setting(logic [SMP_W-1:0] r, logic [SMP_W-1:0] b,
                                 logic [DVS_W-1:0] tp);
        drain();
        write_reg(CFG_SAMPLE_RATE, r);
        write_reg(CFG_BUFFER_SAMPLES, b);
        write_reg(CFG_TICKS_PER_SECOND, tp);
        settings++;
    endtask

    // one random register setting followed by a run of mostly well-formed polls
    task automatic random_phase(int unsigned items, bit hold);
        logic [SMP_W-1:0]  r;
        logic [SMP_W-1:0]  b;
        logic [DVS_W-1:0]  tp;
        logic [TIME_W-1:0] now;
        longint unsigned   span;
        int                thr;
        int                pick;
        int                samples;
        r  = ($urandom_range(0, 3) == 0) ? SMP_W'($urandom_range(1, 65535))
                                         : SMP_W'($urandom_range(2, 48000));
        b  = ($urandom_range(0, 4) == 0) ? SMP_W'($urandom_range(2, 65535))
                                         : SMP_W'($urandom_range(2, 300));
        tp = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1000, 2000000);
        apply_setting(r, b, tp);
        // some phases run back to back with no gaps on either side
        no_gaps = hold || ($urandom_range(0, 3) == 0);
        if (hold)
            hold_pending = 1'b1;
        thr = ((r < b) ? r : b) >> 1;
        now = $urandom;
        // usually a fresh stream, sometimes carry on with the old one
        if ($urandom_range(0, 4) != 0)
            send_word(KIND_START, now);
        repeat (items)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
            begin
                // time step worth a chosen number of samples, plus jitter
                samples = $urandom_range(0, 3 * thr + 4);
                span    = 64'(samples) * tp / r + $urandom_range(0, 50);
                if (span > 64'hFFFF_FFFF)
                    span = 64'hFFFF_FFFF;
                now = now + span[TIME_W-1:0];
                send_word(KIND_POLL, now);
            end
            else if (pick < 16)
            begin
                // time running backwards
                now = now - $urandom_range(1, 5000);
                send_word(KIND_POLL, now);
            end
            else if (pick < 18)
            begin
                now = $urandom;
                send_word(KIND_POLL, now);
            end
            else if (pick < 19)
            begin
                now = now + $urandom_range(0, 1000);
                send_word(KIND_START, now);
            end
            else
            begin
                now = $urandom;
                send_word(1'($urandom_range(0, 1)), now);
            end
        end
    endtask

    // refill word checker, samples the values the block saw at the edge
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_word(fill_offset, fill_count, last, overrun, played_total);
    end

    // receiver: random stall per refill word, one long hold-off on request
    initial
    begin : receiver
        int gap;
        out_stall <= 1'b1;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                gap = HOLD_CYCLES;
            end
            else
            begin
                gap = no_gaps ? 0 : $urandom_range(0, 9);
            end
            if (gap != 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        kind      <= KIND_START;
        bus_time  <= '0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_SAMPLE_RATE;
        cfg_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults, nothing written yet
        settings = 1;
        send_word(KIND_POLL, 32'd0);                 // empty ring right after reset
        send_word(KIND_START, 32'd1000);
        send_word(KIND_POLL, 32'd1000);              // no time elapsed
        send_word(KIND_POLL, 32'd500);               // time before reference
        send_word(KIND_POLL, 32'd500 + 32'd1023 * 32'd3000);
        send_word(KIND_POLL, 32'hFFFF_FFFF);         // long gap, request cap hit
        send_word(KIND_START, 32'hFFFF_FFFF);
        send_word(KIND_POLL, 32'hFFFF_FFFF);
        send_word(KIND_POLL, 32'd0);

        // all registers at their top values
        apply_setting(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(KIND_POLL, 32'h7FFF_FFFF);
        send_word(KIND_POLL, 32'hFFFF_FFFF);
        send_word(KIND_START, 32'h5555_5555);
        send_word(KIND_POLL, 32'hAAAA_AAAA);

        // short ring with the old write offset still past its end,
        // then one tick per second for a deep underrun
        apply_setting(16'hFFFF, 16'd64, 32'd1);
        send_word(KIND_POLL, 32'hAAAA_AAAA + 32'd100);
        send_word(KIND_START, 32'd0);
        send_word(KIND_POLL, 32'hFFFF_FFFF);
        send_word(KIND_POLL, 32'hFFFF_FFFF);

        // zero sample rate, and a write to the unused index
        apply_setting(16'd0, 16'd2, TPS_RESET);
        write_reg(CFG_UNUSED, $urandom);
        send_word(KIND_START, 32'd100);
        send_word(KIND_POLL, 32'd5000);

        // lowest rate and ring, zero tick rate: threshold is zero
        apply_setting(16'd1, 16'd2, 32'd0);
        send_word(KIND_POLL, 32'd7);

        // smallest ring with a threshold of one
        apply_setting(16'd3, 16'd2, 32'd0);
        send_word(KIND_START, 32'd9);
        send_word(KIND_POLL, 32'hFFFF_FFFF);

        // random settings, the second one with the long receiver hold-off
        for (int i = 0; i < RANDOM_SETTINGS; i++)
            random_phase(WORDS_PER_SETTING, i == 1);

        no_gaps = 1'b0;
        drain();

        $display("covered %0d start and %0d poll words over %0d register settings",
                 starts, polls, settings);
        $display("checked %0d refill words, %0d with overrun set, %0d errors",
                 sb.checked, sb.overruns, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
